/* src/adcavg_pkg.sv */
package adcavg_pkg;

  // Default converter resolution
  localparam int unsigned SampleBitsDef = 10;

  // Stream and register port widths
  localparam int unsigned InTdataW  = 16;
  localparam int unsigned OutTdataW = 32;
  localparam int unsigned OutTuserW = 2;
  localparam int unsigned CfgIdxW   = 4;
  localparam int unsigned CfgDataW  = 16;

  // Register map
  localparam logic [CfgIdxW-1:0] RegSampleCount    = 4'd0;
  localparam logic [CfgIdxW-1:0] RegAlarmThreshold = 4'd1;

  localparam logic [7:0] SampleCountRst    = 8'd100;
  localparam logic [8:0] AlarmThresholdRst = 9'd40;

  // Scaling: full scale reads 500.00 degrees
  localparam int unsigned   QuotW           = 16;
  localparam logic [15:0]   HundredthsAtFull = 16'd50000;
  localparam logic [15:0]   DegreesAtFull    = 16'd500;
  localparam logic [15:0]   DisplayMax       = 16'd9999;
  localparam int unsigned   BinBits          = 14;
  localparam int unsigned   StepCntW         = 4;
  localparam logic [StepCntW-1:0] DivLastStep = StepCntW'(QuotW - 1);
  localparam logic [StepCntW-1:0] BcdLastStep = StepCntW'(BinBits - 1);

  typedef enum logic [3:0] {
    ST_ACCUM,
    ST_MUL_DEN,
    ST_MUL_NUM,
    ST_MUL_LHS,
    ST_MUL_RHS,
    ST_ALARM,
    ST_DIVIDE,
    ST_BCD_LOAD,
    ST_CONVERT,
    ST_DELIVER
  } state_e;

  typedef enum logic [2:0] {
    MUL_IDLE,
    MUL_DEN,
    MUL_NUM,
    MUL_LHS,
    MUL_RHS
  } mul_sel_e;

  typedef struct packed {
    logic     in_ready;
    mul_sel_e mul_sel;
    logic     alarm_upd;
    logic     div_load;
    logic     div_step;
    logic     bcd_load;
    logic     bcd_step;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic block_end;
    logic out_free;
  } dp_status_t;

endpackage

/* src/adcavg_ctrl.sv */
module adcavg_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  adcavg_pkg::dp_status_t status_i,
  output adcavg_pkg::ctrl_cmd_t  cmd_o
);
  import adcavg_pkg::*;

  state_e               state_q, state_d;
  logic [StepCntW-1:0]  step_q, step_d;
  logic                 div_last, bcd_last;

  assign div_last = (step_q == DivLastStep);
  assign bcd_last = (step_q == BcdLastStep);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCUM;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    step_d  = '0;
    case (state_q)
      ST_ACCUM: begin
        if (in_valid_i && status_i.block_end) begin
          state_d = ST_MUL_DEN;
        end
      end
      ST_MUL_DEN:  state_d = ST_MUL_NUM;
      ST_MUL_NUM:  state_d = ST_MUL_LHS;
      ST_MUL_LHS:  state_d = ST_MUL_RHS;
      ST_MUL_RHS:  state_d = ST_ALARM;
      ST_ALARM:    state_d = ST_DIVIDE;
      ST_DIVIDE: begin
        if (div_last) begin
          state_d = ST_BCD_LOAD;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_BCD_LOAD: state_d = ST_CONVERT;
      ST_CONVERT: begin
        if (bcd_last) begin
          state_d = ST_DELIVER;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_DELIVER: begin
        if (status_i.out_free) begin
          state_d = ST_ACCUM;
        end
      end
      default: state_d = ST_ACCUM;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '{in_ready: 1'b0, mul_sel: MUL_IDLE, alarm_upd: 1'b0, div_load: 1'b0,
              div_step: 1'b0, bcd_load: 1'b0, bcd_step: 1'b0, out_load: 1'b0};
    case (state_q)
      ST_ACCUM:    cmd_o.in_ready = 1'b1;
      ST_MUL_DEN:  cmd_o.mul_sel  = MUL_DEN;
      ST_MUL_NUM:  cmd_o.mul_sel  = MUL_NUM;
      ST_MUL_LHS:  cmd_o.mul_sel  = MUL_LHS;
      ST_MUL_RHS:  cmd_o.mul_sel  = MUL_RHS;
      ST_ALARM: begin
        cmd_o.alarm_upd = 1'b1;
        cmd_o.div_load  = 1'b1;
      end
      ST_DIVIDE:   cmd_o.div_step = 1'b1;
      ST_BCD_LOAD: cmd_o.bcd_load = 1'b1;
      ST_CONVERT:  cmd_o.bcd_step = 1'b1;
      ST_DELIVER:  cmd_o.out_load = status_i.out_free;
      default:     cmd_o.in_ready = 1'b0;
    endcase
  end

endmodule

/* src/adcavg_datapath.sv */
module adcavg_datapath #(
  parameter int unsigned SAMPLE_BITS = adcavg_pkg::SampleBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [adcavg_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [adcavg_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  input  logic [SAMPLE_BITS-1:0]              sample_i,
  input  adcavg_pkg::ctrl_cmd_t               cmd_i,
  output adcavg_pkg::dp_status_t              status_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [adcavg_pkg::OutTdataW-1:0]    out_data_o,
  output logic [adcavg_pkg::OutTuserW-1:0]    out_user_o
);
  import adcavg_pkg::*;

  localparam int unsigned SumW  = SAMPLE_BITS + 8;
  localparam int unsigned DenW  = SAMPLE_BITS + 9;
  localparam int unsigned NumW  = SumW + QuotW;
  localparam int unsigned LhsW  = SumW + 9;
  localparam int unsigned RhsW  = DenW + 9;
  localparam int unsigned ProdW = DenW + 16;
  localparam logic [SAMPLE_BITS-1:0] FullScale = {SAMPLE_BITS{1'b1}};

  // configuration
  logic [7:0] count_q;
  logic [8:0] thresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= SampleCountRst;
      thresh_q <= AlarmThresholdRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegSampleCount:    count_q  <= cfg_data_i[7:0];
        RegAlarmThreshold: thresh_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // accumulation
  logic            acc_en;
  logic [SumW-1:0] sum_q, sum_add;
  logic [7:0]      idx_q, idx_inc, count_eff;

  assign acc_en    = in_valid_i && cmd_i.in_ready;
  assign idx_inc   = idx_q + 8'd1;
  assign count_eff = (count_q == 8'd0) ? 8'd1 : count_q;
  assign sum_add   = sum_q + SumW'(sample_i);
  // counter wraps to zero only after 256 samples
  assign status_o.block_end = (idx_inc == 8'd0) || (idx_inc >= count_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      idx_q <= '0;
    end else if (acc_en) begin
      if (status_o.block_end) begin
        sum_q <= '0;
        idx_q <= '0;
      end else begin
        sum_q <= sum_add;
        idx_q <= idx_inc;
      end
    end
  end

  logic [SumW-1:0] blk_sum_q;
  logic [8:0]      n_q;

  always_ff @(posedge clk_i) begin
    if (acc_en && status_o.block_end) begin
      blk_sum_q <= sum_add;
      n_q       <= {idx_inc == 8'd0, idx_inc};
    end
  end

  // shared multiplier
  logic [DenW-1:0]  mul_a;
  logic [15:0]      mul_b;
  logic [ProdW-1:0] prod;
  logic [DenW-1:0]  den_q;
  logic [NumW-1:0]  num_q;
  logic [LhsW-1:0]  lhs_q;
  logic [RhsW-1:0]  rhs_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      MUL_DEN: begin
        mul_a = DenW'(FullScale);
        mul_b = 16'(n_q);
      end
      MUL_NUM: begin
        mul_a = DenW'(blk_sum_q);
        mul_b = HundredthsAtFull;
      end
      MUL_LHS: begin
        mul_a = DenW'(blk_sum_q);
        mul_b = DegreesAtFull;
      end
      MUL_RHS: begin
        mul_a = den_q;
        mul_b = 16'(thresh_q);
      end
      default: ;
    endcase
  end

  assign prod = ProdW'(mul_a) * ProdW'(mul_b);

  always_ff @(posedge clk_i) begin
    case (cmd_i.mul_sel)
      MUL_DEN: den_q <= prod[DenW-1:0];
      MUL_NUM: num_q <= prod[NumW-1:0];
      MUL_LHS: lhs_q <= prod[LhsW-1:0];
      MUL_RHS: rhs_q <= prod[RhsW-1:0];
      default: ;
    endcase
  end

  // latched alarm; equality keeps it
  logic alarm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_q <= 1'b0;
    end else if (cmd_i.alarm_upd) begin
      if (RhsW'(lhs_q) > rhs_q) begin
        alarm_q <= 1'b1;
      end else if (RhsW'(lhs_q) < rhs_q) begin
        alarm_q <= 1'b0;
      end
    end
  end

  // restoring divider, one quotient bit a cycle; the quotient fits in QuotW bits
  // so the top part of the numerator already sits below the divisor
  logic [DenW-1:0]  rem_q;
  logic [QuotW-1:0] quo_q;
  logic [DenW:0]    trial;
  logic             fits;

  assign trial = {rem_q, quo_q[QuotW-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      rem_q <= DenW'(num_q[NumW-1:QuotW]);
      quo_q <= num_q[QuotW-1:0];
    end else if (cmd_i.div_step) begin
      rem_q <= fits ? DenW'(trial - {1'b0, den_q}) : trial[DenW-1:0];
      quo_q <= {quo_q[QuotW-2:0], fits};
    end
  end

  // saturate, then double dabble one bit a cycle
  logic               over_q;
  logic [BinBits-1:0] bin_q;
  logic [15:0]        bcd_q, bcd_adj;

  always_comb begin
    for (int d = 0; d < 4; d++) begin
      bcd_adj[d*4 +: 4] = (bcd_q[d*4 +: 4] >= 4'd5) ? bcd_q[d*4 +: 4] + 4'd3
                                                     : bcd_q[d*4 +: 4];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.bcd_load) begin
      over_q <= (quo_q > DisplayMax);
      bin_q  <= (quo_q > DisplayMax) ? DisplayMax[BinBits-1:0] : quo_q[BinBits-1:0];
      bcd_q  <= '0;
    end else if (cmd_i.bcd_step) begin
      bcd_q <= {bcd_adj[14:0], bin_q[BinBits-1]};
      bin_q <= {bin_q[BinBits-2:0], 1'b0};
    end
  end

  // output register
  logic out_valid_q;

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_o <= {bcd_q[3:0], bcd_q[7:4], bcd_q[11:8], bcd_q[15:12], quo_q};
      out_user_o <= {alarm_q, over_q};
    end
  end

endmodule

/* src/adc_average_temperature_alarm.sv */
// Channel   Dir  Beat contents (low bits first)
// s_axis    in   tdata: adc_sample
// m_axis    out  tdata: temp_hundredths, digit_thousands, digit_hundreds,
//                        digit_tens, digit_units; tuser: over_range, alarm_on
// cfg       in   cfg_index_i selects sample_count (0) or alarm_threshold (1)
//
// A sample that does not end a block leaves the input ready for the next sample.
// The sample that ends a block starts a run on one shared multiplier
// (4 products), a 16-step restoring divider and a 14-step BCD converter;
// input is held off until the result enters the output register.
// m_axis stalls only delay that load; input stays held off meanwhile.
// rst_ni clears the sum, the counter and the alarm; registers return to 100 and 40.
module adc_average_temperature_alarm #(
  parameter int unsigned SAMPLE_BITS = adcavg_pkg::SampleBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [adcavg_pkg::InTdataW-1:0]     s_axis_tdata_i,  // [9:0] adc_sample
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [15:0] temp_hundredths, [19:16] digit_thousands, [23:20] digit_hundreds,
  // [27:24] digit_tens, [31:28] digit_units
  output logic [adcavg_pkg::OutTdataW-1:0]    m_axis_tdata_o,
  output logic [adcavg_pkg::OutTuserW-1:0]    m_axis_tuser_o,  // [0] over_range, [1] alarm_on
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [adcavg_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [adcavg_pkg::CfgDataW-1:0]     cfg_data_i
);
  import adcavg_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = cmd.in_ready;

  adcavg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  adcavg_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid_i),
    .sample_i    (s_axis_tdata_i[SAMPLE_BITS-1:0]),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o)
  );

endmodule

/* src/adcavg_checker.sv */
module adcavg_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid_i,
  input logic                             m_axis_tready_i,
  input logic [adcavg_pkg::OutTdataW-1:0] m_axis_tdata_i,
  input logic [adcavg_pkg::OutTuserW-1:0] m_axis_tuser_i
);
  import adcavg_pkg::*;

  logic [15:0] temp;
  logic [3:0]  d_th, d_hu, d_te, d_un;
  logic [16:0] dec_val;
  logic        over;

  assign temp    = m_axis_tdata_i[15:0];
  assign d_th    = m_axis_tdata_i[19:16];
  assign d_hu    = m_axis_tdata_i[23:20];
  assign d_te    = m_axis_tdata_i[27:24];
  assign d_un    = m_axis_tdata_i[31:28];
  assign over    = m_axis_tuser_i[0];
  assign dec_val = 17'(d_th) * 17'd1000 + 17'(d_hu) * 17'd100 + 17'(d_te) * 17'd10
                 + 17'(d_un);

  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> temp <= HundredthsAtFull)
    else $error("temperature beyond full scale");

  a_digits_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_i && !over) |-> ({1'b0, temp} == dec_val && d_th <= 4'd9))
    else $error("digits disagree with temperature");

  a_saturate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_i && over) |->
      (temp > DisplayMax && d_th == 4'd9 && d_hu == 4'd9 && d_te == 4'd9 && d_un == 4'd9))
    else $error("over-range beat not saturated");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_i && !m_axis_tready_i) |=>
      (m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tuser_i)))
    else $error("stalled output beat changed");

endmodule

bind adc_average_temperature_alarm adcavg_checker u_adcavg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o)
);

/* test/tb_adc_average_temperature_alarm.sv */
module tb_adc_average_temperature_alarm;
  import adcavg_pkg::*;

  localparam int unsigned    LatencyCycles = 48;   // closing run plus margin
  localparam int unsigned    MaxReported   = 10;
  localparam int unsigned    RandomItems   = 550;
  localparam longint         RunLimit      = 4_000_000;
  localparam longint unsigned FullScale    = (64'd1 << SampleBitsDef) - 64'd1;
  localparam logic [CfgIdxW-1:0] RegUnmapped = 4'd9;

  typedef struct packed {
    logic [15:0] temp;
    logic [3:0]  thousands;
    logic [3:0]  hundreds;
    logic [3:0]  tens;
    logic [3:0]  units;
    logic        over;
    logic        alarm;
  } reading_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [InTdataW-1:0]  s_axis_tdata_i;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [OutTdataW-1:0] m_axis_tdata_o;
  logic [OutTuserW-1:0] m_axis_tuser_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;

  adc_average_temperature_alarm DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow of the block: registers, running sum, sample counter, alarm latch
  logic [7:0]  count_reg     = SampleCountRst;
  logic [8:0]  thresh_reg    = AlarmThresholdRst;
  logic [17:0] acc_sum       = '0;
  logic [7:0]  acc_n         = '0;
  logic        alarm_latched = 1'b0;

  reading_t    pending_readings[$];
  int unsigned error_count = 0;
  int unsigned samples_sent = 0;
  bit          idle_en = 1'b1;
  int unsigned rx_wait = 0;
  int unsigned rx_draw;

  task automatic accumulate_sample(input logic [9:0] smp);
    int unsigned       blk_len;
    longint unsigned   n, sum_v, temp, lhs, rhs, shown;
    reading_t          r;
    blk_len = (count_reg == 8'd0) ? 1 : count_reg;
    acc_sum = acc_sum + smp;
    acc_n   = acc_n + 8'd1;
    if (acc_n != 8'd0 && acc_n < blk_len) return;
    n     = (acc_n == 8'd0) ? 256 : acc_n;
    sum_v = acc_sum;
    temp  = (sum_v * HundredthsAtFull) / (FullScale * n);
    // alarm compares the exact average; equality holds the latch
    lhs = sum_v * DegreesAtFull;
    rhs = FullScale * n * thresh_reg;
    if (lhs > rhs) alarm_latched = 1'b1;
    else if (lhs < rhs) alarm_latched = 1'b0;
    shown       = (temp > DisplayMax) ? DisplayMax : temp;
    r.temp      = temp[15:0];
    r.thousands = 4'((shown / 1000) % 10);
    r.hundreds  = 4'((shown / 100) % 10);
    r.tens      = 4'((shown / 10) % 10);
    r.units     = 4'(shown % 10);
    r.over      = (temp > DisplayMax);
    r.alarm     = alarm_latched;
    pending_readings.push_back(r);
    acc_sum = '0;
    acc_n   = '0;
  endtask

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned seen);
    if (want != seen) begin
      if (error_count < MaxReported)
        $display("mismatch on %s: expected %0d, got %0d", name, want, seen);
      error_count++;
    end
  endfunction

  task automatic check_reading();
    reading_t got, want;
    got.temp      = m_axis_tdata_o[15:0];
    got.thousands = m_axis_tdata_o[19:16];
    got.hundreds  = m_axis_tdata_o[23:20];
    got.tens      = m_axis_tdata_o[27:24];
    got.units     = m_axis_tdata_o[31:28];
    got.over      = m_axis_tuser_o[0];
    got.alarm     = m_axis_tuser_o[1];
    if (pending_readings.size() == 0) begin
      if (error_count < MaxReported)
        $display("unexpected reading: temp_hundredths %0d", got.temp);
      error_count++;
      return;
    end
    want = pending_readings.pop_front();
    compare_field("temp_hundredths", want.temp, got.temp);
    compare_field("digit_thousands", want.thousands, got.thousands);
    compare_field("digit_hundreds", want.hundreds, got.hundreds);
    compare_field("digit_tens", want.tens, got.tens);
    compare_field("digit_units", want.units, got.units);
    compare_field("over_range", want.over, got.over);
    compare_field("alarm_on", want.alarm, got.alarm);
  endtask

  // Result side: check every beat, then, with idle_en set, may hold tready low until a random rx_wait runs out
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      rx_wait <= 0;
    end else if (m_axis_tvalid_o && m_axis_tready_i) begin
      check_reading();
      rx_draw = idle_en ? $urandom_range(0, 3) : 0;
      if (rx_draw != 0) begin
        m_axis_tready_i <= 1'b0;
        rx_wait <= rx_draw - 1;
      end
    end else if (!m_axis_tready_i) begin
      if (rx_wait == 0) m_axis_tready_i <= 1'b1;
      else rx_wait <= rx_wait - 1;
    end
  end

  // Leaves tvalid high on return; the caller's next drive in this step decides it
  task automatic send_sample(input logic [9:0] smp);
    int unsigned gap;
    gap = idle_en ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(InTdataW - 10){1'b0}}, smp};
    do @(posedge clk_i); while (!s_axis_tready_o);
    accumulate_sample(smp);
    samples_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (LatencyCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == RegSampleCount) count_reg = data[7:0];
    else if (idx == RegAlarmThreshold) thresh_reg = data[8:0];
  endtask

  task automatic test_reset_values();
    repeat (SampleCountRst) send_sample(10'($urandom_range(0, 1023)));
    drain();
  endtask

  task automatic test_extremes();
    write_reg(RegSampleCount, 16'd1);
    send_sample(10'd0);
    send_sample(10'd1023);
    send_sample(10'd1);
    send_sample(10'h2AA);
    send_sample(10'h155);
    send_sample(10'd204);   // just below the display limit
    send_sample(10'd205);   // just above it
    drain();
  endtask

  task automatic test_alarm_hysteresis();
    write_reg(RegAlarmThreshold, 16'd0);
    send_sample(10'd0);     // level with limit: latch holds
    send_sample(10'd1);
    write_reg(RegAlarmThreshold, 16'd500);
    send_sample(10'd1023);  // full scale equals the limit
    send_sample(10'd1022);
    write_reg(RegAlarmThreshold, 16'd0);
    send_sample(10'd1023);
    write_reg(RegAlarmThreshold, 16'd511);
    send_sample(10'd1023);  // limit beyond full scale still clears
    send_sample(10'd1023);
    write_reg(RegSampleCount, 16'd2);
    write_reg(RegAlarmThreshold, 16'd250);
    send_sample(10'd511);
    send_sample(10'd512);   // exact average of 250 degrees
    drain();
  endtask

  task automatic test_zero_count();
    write_reg(RegSampleCount, 16'd0);
    repeat (3) send_sample(10'($urandom_range(0, 1023)));
    drain();
  endtask

  task automatic test_count_lowered();
    write_reg(RegSampleCount, 16'd10);
    repeat (5) send_sample(10'($urandom_range(0, 1023)));
    write_reg(RegSampleCount, 16'd3);
    send_sample(10'($urandom_range(0, 1023)));
    drain();
  endtask

  task automatic test_register_masking();
    write_reg(RegUnmapped, 16'hFFFF);
    write_reg(RegSampleCount, 16'hFF02);
    write_reg(RegAlarmThreshold, 16'hFE28);
    send_sample(10'($urandom_range(0, 1023)));
    send_sample(10'($urandom_range(0, 1023)));
    drain();
  endtask

  task automatic test_random_traffic();
    int unsigned pick, eff, items, level;
    int          v;
    logic [7:0]  cnt;
    logic [8:0]  thr;
    bit          long_done;
    long_done = 1'b0;
    while (samples_sent < RandomItems + SampleCountRst) begin
      pick = $urandom_range(0, 19);
      if (pick == 0 && !long_done) begin
        cnt = 8'd255;
        long_done = 1'b1;
      end else if (pick == 1) cnt = 8'd0;
      else if (pick < 5) cnt = 8'($urandom_range(9, 40));
      else cnt = 8'($urandom_range(1, 8));
      pick = $urandom_range(0, 9);
      if (pick == 0) thr = 9'd0;
      else if (pick == 1) thr = 9'd500;
      else if (pick == 2) thr = 9'd511;
      else thr = 9'($urandom_range(0, 511));
      write_reg(RegSampleCount, {8'($urandom), cnt});
      write_reg(RegAlarmThreshold, {7'($urandom), thr});
      idle_en = ($urandom_range(0, 3) != 0);
      eff = (cnt == 8'd0) ? 1 : cnt;
      // a trailing partial block carries into the next setting
      items = ((cnt == 8'd255) ? 1 : $urandom_range(2, 6)) * eff + $urandom_range(0, eff - 1);
      level = $urandom_range(0, 1023);
      repeat (items) begin
        if ($urandom_range(0, 7) == 0) v = $urandom_range(0, 1023);
        else v = int'(level) + int'($urandom_range(0, 16)) - 8;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        send_sample(10'(v));
        if ($urandom_range(0, 49) == 0) drain();
        if ($urandom_range(0, 15) == 0) level = $urandom_range(0, 1023);
      end
      drain();
    end
    idle_en = 1'b1;
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_extremes();
    test_alarm_hysteresis();
    test_zero_count();
    test_count_lowered();
    test_register_masking();
    test_random_traffic();
    drain();
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(RunLimit);
    $display("timeout with %0d readings outstanding", pending_readings.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
